[src/tcsa_pkg.sv]
// Shared widths, register codes, reset values and types for the touch calibration core.
package tcsa_pkg;

   localparam int RAW_W      = 12;
   localparam int PIX_W      = 10;
   localparam int FLAG_W     = 3;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 12;

   localparam int AVG_DEPTH  = 4;
   localparam int FILL_W     = $clog2(AVG_DEPTH + 1);
   localparam int SUM_W      = PIX_W + $clog2(AVG_DEPTH);

   localparam int PROD_W     = RAW_W + PIX_W;
   localparam int DIV_STEP   = 4;
   localparam int DIVIDEND_W = ((PROD_W + DIV_STEP - 1) / DIV_STEP) * DIV_STEP;
   localparam int DIVISOR_W  = RAW_W;
   localparam int DIV_PASSES = DIVIDEND_W / DIV_STEP;
   localparam int DIV_CNT_W  = $clog2(DIV_PASSES);

   localparam logic [PIX_W-1:0] PIX_MAX = '1;

   localparam logic [CSR_ADDR_W-1:0] CSR_RAW_X_MIN     = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_RAW_X_MAX     = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_RAW_Y_MIN     = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_RAW_Y_MAX     = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_SCREEN_WIDTH  = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] CSR_SCREEN_HEIGHT = 3'd5;
   localparam logic [CSR_ADDR_W-1:0] CSR_ORIENT_FLAGS  = 3'd6;

   localparam int FLAG_SWAP  = 0;
   localparam int FLAG_INV_X = 1;
   localparam int FLAG_INV_Y = 2;

   localparam logic [RAW_W-1:0]  RST_RAW_X_MIN     = 12'd400;
   localparam logic [RAW_W-1:0]  RST_RAW_X_MAX     = 12'd3750;
   localparam logic [RAW_W-1:0]  RST_RAW_Y_MIN     = 12'd255;
   localparam logic [RAW_W-1:0]  RST_RAW_Y_MAX     = 12'd3900;
   localparam logic [PIX_W-1:0]  RST_SCREEN_WIDTH  = 10'd128;
   localparam logic [PIX_W-1:0]  RST_SCREEN_HEIGHT = 10'd160;
   localparam logic [FLAG_W-1:0] RST_ORIENT_FLAGS  = 3'd0;

   typedef enum logic [2:0] {
      LANE_IDLE,
      LANE_MUL,
      LANE_SCALE,
      LANE_SUM,
      LANE_AVG,
      LANE_DONE
   } lane_state_type;

   typedef struct packed {
      logic             start;
      logic [RAW_W-1:0] raw;
      logic [RAW_W-1:0] lo;
      logic [RAW_W-1:0] hi;
      logic [PIX_W-1:0] res;
      logic             invert;
   } lane_cmd_type;

   typedef struct packed {
      logic             idle;
      logic             valid;
      logic [PIX_W-1:0] pix;
   } lane_status_type;

endpackage

[src/tcsa_req_if.sv]
// Request channel: one raw touch sample pair.
interface tcsa_req_if import tcsa_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [RAW_W-1:0] raw_x;
   logic [RAW_W-1:0] raw_y;

   modport source (output valid, output raw_x, output raw_y, input ready);
   modport sink   (input valid, input raw_x, input raw_y, output ready);
endinterface

[src/tcsa_rsp_if.sv]
// Response channel: one averaged pixel coordinate pair.
interface tcsa_rsp_if import tcsa_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] pixel_x;
   logic [PIX_W-1:0] pixel_y;

   modport source (output valid, output pixel_x, output pixel_y, input ready);
   modport sink   (input valid, input pixel_x, input pixel_y, output ready);
endinterface

[src/tcsa_csr_if.sv]
// Configuration write channel: register index and write data.
interface tcsa_csr_if import tcsa_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_ADDR_W-1:0] addr;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, output addr, output data, input ready);
   modport sink   (input valid, input addr, input data, output ready);
endinterface

[src/touch_coordinate_scale_average_core.sv]
// Top level of the touch calibration and moving average core.
//
//   channel   dir   fields                      handshake
//   req_if    in    raw_x[11:0] raw_y[11:0]     valid/ready
//   rsp_if    out   pixel_x[9:0] pixel_y[9:0]   valid/ready
//   csr_if    in    addr[2:0] data[11:0]        valid/ready, ready tied high
//
// A request runs from accept to a valid response through a multiply step, a first pass of
// the per-lane divider (6 steps at 4 quotient bits plus done) for the scale, a sum step, a
// second divider pass for the average and a handoff to the output register, which waits
// while that register is still full and not yet taken. X and y lanes run in parallel.
// Next request is accepted once both lanes have handed results to the output
// register, even while that register still waits on rsp_if.ready.
// Synchronous reset restores register defaults and clears history and fill count.
module touch_coordinate_scale_average_core import tcsa_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   tcsa_req_if.sink   req_if,
   tcsa_rsp_if.source rsp_if,
   tcsa_csr_if.sink   csr_if
);

   logic [RAW_W-1:0]  raw_x_min_ff, raw_x_min_in;
   logic [RAW_W-1:0]  raw_x_max_ff, raw_x_max_in;
   logic [RAW_W-1:0]  raw_y_min_ff, raw_y_min_in;
   logic [RAW_W-1:0]  raw_y_max_ff, raw_y_max_in;
   logic [PIX_W-1:0]  screen_width_ff, screen_width_in;
   logic [PIX_W-1:0]  screen_height_ff, screen_height_in;
   logic [FLAG_W-1:0] orient_flags_ff, orient_flags_in;
   logic [FILL_W-1:0] fill_ff, fill_in;

   logic              accept;
   logic              take;
   lane_cmd_type      cmd_x, cmd_y;
   lane_status_type   status_x, status_y;

   assign csr_if.ready = 1'b1;
   assign req_if.ready = status_x.idle && status_y.idle;
   assign accept       = req_if.valid && req_if.ready;

   always_comb begin
      raw_x_min_in     = raw_x_min_ff;
      raw_x_max_in     = raw_x_max_ff;
      raw_y_min_in     = raw_y_min_ff;
      raw_y_max_in     = raw_y_max_ff;
      screen_width_in  = screen_width_ff;
      screen_height_in = screen_height_ff;
      orient_flags_in  = orient_flags_ff;
      if (csr_if.valid) begin
         case (csr_if.addr)
            CSR_RAW_X_MIN:     raw_x_min_in     = csr_if.data[RAW_W-1:0];
            CSR_RAW_X_MAX:     raw_x_max_in     = csr_if.data[RAW_W-1:0];
            CSR_RAW_Y_MIN:     raw_y_min_in     = csr_if.data[RAW_W-1:0];
            CSR_RAW_Y_MAX:     raw_y_max_in     = csr_if.data[RAW_W-1:0];
            CSR_SCREEN_WIDTH:  screen_width_in  = csr_if.data[PIX_W-1:0];
            CSR_SCREEN_HEIGHT: screen_height_in = csr_if.data[PIX_W-1:0];
            CSR_ORIENT_FLAGS:  orient_flags_in  = csr_if.data[FLAG_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      fill_in = fill_ff;
      if (accept && fill_ff != FILL_W'(AVG_DEPTH)) fill_in = fill_ff + 1'b1;
   end

   always_comb begin
      cmd_x.start  = accept;
      cmd_x.raw    = orient_flags_ff[FLAG_SWAP] ? req_if.raw_y : req_if.raw_x;
      cmd_x.lo     = raw_x_min_ff;
      cmd_x.hi     = raw_x_max_ff;
      cmd_x.res    = screen_width_ff;
      cmd_x.invert = orient_flags_ff[FLAG_INV_X];
      cmd_y.start  = accept;
      cmd_y.raw    = orient_flags_ff[FLAG_SWAP] ? req_if.raw_x : req_if.raw_y;
      cmd_y.lo     = raw_y_min_ff;
      cmd_y.hi     = raw_y_max_ff;
      cmd_y.res    = screen_height_ff;
      cmd_y.invert = orient_flags_ff[FLAG_INV_Y];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         raw_x_min_ff     <= RST_RAW_X_MIN;
         raw_x_max_ff     <= RST_RAW_X_MAX;
         raw_y_min_ff     <= RST_RAW_Y_MIN;
         raw_y_max_ff     <= RST_RAW_Y_MAX;
         screen_width_ff  <= RST_SCREEN_WIDTH;
         screen_height_ff <= RST_SCREEN_HEIGHT;
         orient_flags_ff  <= RST_ORIENT_FLAGS;
         fill_ff          <= '0;
      end else begin
         raw_x_min_ff     <= raw_x_min_in;
         raw_x_max_ff     <= raw_x_max_in;
         raw_y_min_ff     <= raw_y_min_in;
         raw_y_max_ff     <= raw_y_max_in;
         screen_width_ff  <= screen_width_in;
         screen_height_ff <= screen_height_in;
         orient_flags_ff  <= orient_flags_in;
         fill_ff          <= fill_in;
      end
   end

   tcsa_lane u_lane_x (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd_x),
      .fill_count (fill_ff),
      .take       (take),
      .status     (status_x)
   );

   tcsa_lane u_lane_y (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd_y),
      .fill_count (fill_ff),
      .take       (take),
      .status     (status_y)
   );

   tcsa_merge u_merge (
      .clock    (clock),
      .reset    (reset),
      .status_x (status_x),
      .status_y (status_y),
      .take     (take),
      .rsp_if   (rsp_if)
   );

endmodule

[src/tcsa_div.sv]
// Iterative restoring divider, several quotient bits per cycle.
module tcsa_div import tcsa_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DIVIDEND_W-1:0] dividend,
   input  logic [DIVISOR_W-1:0]  divisor,
   output logic                  done,
   output logic [DIVIDEND_W-1:0] quotient
);

   localparam logic [DIV_CNT_W-1:0] CNT_LAST = DIV_CNT_W'(DIV_PASSES - 1);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [DIV_CNT_W-1:0]  cnt_ff, cnt_in;
   logic [DIVISOR_W:0]    rem_ff, rem_in;
   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [DIVISOR_W-1:0]  divisor_ff, divisor_in;
   logic [DIVISOR_W:0]    rem_step;
   logic [DIVIDEND_W-1:0] quo_step;

   always_comb begin
      rem_step = rem_ff;
      quo_step = quo_ff;
      for (int i = 0; i < DIV_STEP; i++) begin
         rem_step = {rem_step[DIVISOR_W-1:0], quo_step[DIVIDEND_W-1]};
         quo_step = {quo_step[DIVIDEND_W-2:0], 1'b0};
         if (rem_step >= {1'b0, divisor_ff}) begin
            rem_step    = rem_step - {1'b0, divisor_ff};
            quo_step[0] = 1'b1;
         end
      end
   end

   always_comb begin
      busy_in    = busy_ff;
      done_in    = 1'b0;
      cnt_in     = cnt_ff;
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      divisor_in = divisor_ff;
      if (start) begin
         busy_in    = 1'b1;
         cnt_in     = '0;
         rem_in     = '0;
         quo_in     = dividend;
         divisor_in = divisor;
      end else if (busy_ff) begin
         rem_in = rem_step;
         quo_in = quo_step;
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      divisor_ff <= divisor_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

[src/tcsa_lane.sv]
// One axis lane: offset, scale, clamp, invert, history and running average.
module tcsa_lane import tcsa_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  lane_cmd_type    cmd,
   input  logic [FILL_W-1:0] fill_count,
   input  logic            take,
   output lane_status_type status
);

   localparam int SUM_X_W = SUM_W + 1;

   lane_state_type        state_ff, state_in;
   logic [RAW_W-1:0]      off_ff, off_in;
   logic [RAW_W-1:0]      span_ff, span_in;
   logic                  span_ok_ff, span_ok_in;
   logic [PIX_W-1:0]      res_ff, res_in;
   logic                  invert_ff, invert_in;
   logic [PIX_W-1:0]      hist_ff [AVG_DEPTH];
   logic [PIX_W-1:0]      hist_in [AVG_DEPTH];
   logic [SUM_W-1:0]      sum_ff, sum_in;
   logic [PIX_W-1:0]      pix_ff, pix_in;

   logic                  div_start;
   logic [DIVIDEND_W-1:0] div_dividend;
   logic [DIVISOR_W-1:0]  div_divisor;
   logic                  div_done;
   logic [DIVIDEND_W-1:0] div_quotient;

   logic [PROD_W-1:0]     prod;
   logic [PIX_W-1:0]      sat;
   logic [PIX_W-1:0]      scaled;
   logic [PIX_W-1:0]      cal;
   logic [SUM_X_W-1:0]    sum_wide;

   tcsa_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quotient)
   );

   assign prod     = PROD_W'(off_ff) * PROD_W'(res_ff);
   assign sat      = (|div_quotient[DIVIDEND_W-1:PIX_W]) ? PIX_MAX : div_quotient[PIX_W-1:0];
   assign scaled   = span_ok_ff ? sat : '0;
   assign cal      = !invert_ff ? scaled : ((res_ff > scaled) ? res_ff - scaled : '0);
   assign sum_wide = SUM_X_W'(sum_ff) + SUM_X_W'(cal) - SUM_X_W'(hist_ff[AVG_DEPTH-1]);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         LANE_IDLE: begin
            if (cmd.start) state_in = LANE_MUL;
         end
         LANE_MUL: begin
            state_in = LANE_SCALE;
         end
         LANE_SCALE: begin
            if (div_done) state_in = LANE_SUM;
         end
         LANE_SUM: begin
            state_in = LANE_AVG;
         end
         LANE_AVG: begin
            if (div_done) state_in = LANE_DONE;
         end
         LANE_DONE: begin
            if (take) state_in = LANE_IDLE;
         end
         default: begin
            state_in = LANE_IDLE;
         end
      endcase
   end

   always_comb begin
      div_start    = 1'b0;
      div_dividend = DIVIDEND_W'(sum_ff);
      div_divisor  = DIVISOR_W'(fill_count);
      case (state_ff)
         LANE_MUL: begin
            div_start    = 1'b1;
            div_dividend = DIVIDEND_W'(prod);
            div_divisor  = span_ff;
         end
         LANE_SUM: begin
            div_start = 1'b1;
         end
         default: begin
         end
      endcase
      status.idle  = (state_ff == LANE_IDLE);
      status.valid = (state_ff == LANE_DONE);
      status.pix   = pix_ff;
   end

   always_comb begin
      off_in     = off_ff;
      span_in    = span_ff;
      span_ok_in = span_ok_ff;
      res_in     = res_ff;
      invert_in  = invert_ff;
      hist_in    = hist_ff;
      sum_in     = sum_ff;
      pix_in     = pix_ff;
      if (state_ff == LANE_IDLE && cmd.start) begin
         off_in     = (cmd.raw > cmd.lo) ? cmd.raw - cmd.lo : '0;
         span_in    = cmd.hi - cmd.lo;
         span_ok_in = (cmd.hi > cmd.lo);
         res_in     = cmd.res;
         invert_in  = cmd.invert;
      end
      if (state_ff == LANE_SCALE && div_done) begin
         for (int i = AVG_DEPTH - 1; i > 0; i--) begin
            hist_in[i] = hist_ff[i-1];
         end
         hist_in[0] = cal;
         sum_in     = sum_wide[SUM_W-1:0];
      end
      if (state_ff == LANE_AVG && div_done) begin
         pix_in = div_quotient[PIX_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= LANE_IDLE;
         sum_ff   <= '0;
         for (int i = 0; i < AVG_DEPTH; i++) begin
            hist_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         sum_ff   <= sum_in;
         hist_ff  <= hist_in;
      end
      off_ff     <= off_in;
      span_ff    <= span_in;
      span_ok_ff <= span_ok_in;
      res_ff     <= res_in;
      invert_ff  <= invert_in;
      pix_ff     <= pix_in;
   end

endmodule

[src/tcsa_merge.sv]
// Merge stage: join both lane results into the response register.
module tcsa_merge import tcsa_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  lane_status_type status_x,
   input  lane_status_type status_y,
   output logic            take,
   tcsa_rsp_if.source      rsp_if
);

   logic             rsp_valid_ff, rsp_valid_in;
   logic [PIX_W-1:0] pix_x_ff, pix_x_in;
   logic [PIX_W-1:0] pix_y_ff, pix_y_in;

   assign take = status_x.valid && status_y.valid && (!rsp_valid_ff || rsp_if.ready);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      pix_x_in     = pix_x_ff;
      pix_y_in     = pix_y_ff;
      if (rsp_valid_ff && rsp_if.ready) rsp_valid_in = 1'b0;
      if (take) begin
         rsp_valid_in = 1'b1;
         pix_x_in     = status_x.pix;
         pix_y_in     = status_y.pix;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      pix_x_ff <= pix_x_in;
      pix_y_ff <= pix_y_in;
   end

   assign rsp_if.valid   = rsp_valid_ff;
   assign rsp_if.pixel_x = pix_x_ff;
   assign rsp_if.pixel_y = pix_y_ff;

endmodule

[test/touch_coordinate_scale_average_core_tb.sv]
// Testbench for the touch calibration and moving average core: directed and random requests.
`timescale 1ns / 100ps

module touch_coordinate_scale_average_core_tb;
   import tcsa_pkg::*;

   localparam logic [CSR_ADDR_W-1:0] CSR_UNUSED = 3'd7;
   localparam int RAW_TOP       = (1 << RAW_W) - 1;
   localparam int HOLD_CYCLES   = 300;
   localparam int SETTLE_CYCLES = 40;
   localparam int TIMEOUT_NS    = 2_000_000;
   localparam int RANDOM_PHASES = 12;
   localparam int PHASE_ITEMS   = 105;

   typedef struct {
      logic [PIX_W-1:0] pix_x;
      logic [PIX_W-1:0] pix_y;
   } touch_point_type;

   logic clock;
   logic reset;

   tcsa_req_if req_if ();
   tcsa_rsp_if rsp_if ();
   tcsa_csr_if csr_if ();

   touch_coordinate_scale_average_core dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   logic [RAW_W-1:0]  cfg_x_min  = RST_RAW_X_MIN;
   logic [RAW_W-1:0]  cfg_x_max  = RST_RAW_X_MAX;
   logic [RAW_W-1:0]  cfg_y_min  = RST_RAW_Y_MIN;
   logic [RAW_W-1:0]  cfg_y_max  = RST_RAW_Y_MAX;
   logic [PIX_W-1:0]  cfg_width  = RST_SCREEN_WIDTH;
   logic [PIX_W-1:0]  cfg_height = RST_SCREEN_HEIGHT;
   logic [FLAG_W-1:0] cfg_flags  = RST_ORIENT_FLAGS;

   logic [PIX_W-1:0] recent_x [AVG_DEPTH] = '{default: '0};
   logic [PIX_W-1:0] recent_y [AVG_DEPTH] = '{default: '0};
   int recent_count = 0;

   touch_point_type expected_points [$];
   int fail_count       = 0;
   int req_gap_max      = 0;
   int rsp_stall_max    = 0;
   int rsp_stall_left   = 0;
   int rsp_hold_left    = 0;
   logic rsp_hold_request;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #(TIMEOUT_NS);
      $display("simulation failed");
      $finish;
   end

   function automatic logic [PIX_W-1:0] calibrate_axis(logic [RAW_W-1:0] raw,
         logic [RAW_W-1:0] lo, logic [RAW_W-1:0] hi, logic [PIX_W-1:0] res, logic invert);
      int unsigned offset;
      int unsigned scaled;
      offset = (raw > lo) ? int'(raw) - int'(lo) : 0;
      scaled = 0;
      if (hi > lo) begin
         scaled = (offset * int'(res)) / (int'(hi) - int'(lo));
         if (scaled > int'(PIX_MAX)) scaled = PIX_MAX;
      end
      if (invert) scaled = (int'(res) > scaled) ? int'(res) - scaled : 0;
      return scaled[PIX_W-1:0];
   endfunction

   function automatic touch_point_type predict_touch(logic [RAW_W-1:0] raw_x,
         logic [RAW_W-1:0] raw_y);
      logic [RAW_W-1:0] axis_x;
      logic [RAW_W-1:0] axis_y;
      int unsigned sum_x;
      int unsigned sum_y;
      touch_point_type point;
      axis_x = cfg_flags[FLAG_SWAP] ? raw_y : raw_x;
      axis_y = cfg_flags[FLAG_SWAP] ? raw_x : raw_y;
      for (int i = AVG_DEPTH - 1; i > 0; i--) begin
         recent_x[i] = recent_x[i-1];
         recent_y[i] = recent_y[i-1];
      end
      recent_x[0] = calibrate_axis(axis_x, cfg_x_min, cfg_x_max, cfg_width,
                                   cfg_flags[FLAG_INV_X]);
      recent_y[0] = calibrate_axis(axis_y, cfg_y_min, cfg_y_max, cfg_height,
                                   cfg_flags[FLAG_INV_Y]);
      if (recent_count < AVG_DEPTH) recent_count++;
      sum_x = 0;
      sum_y = 0;
      for (int i = 0; i < recent_count; i++) begin
         sum_x += recent_x[i];
         sum_y += recent_y[i];
      end
      point.pix_x = PIX_W'(sum_x / recent_count);
      point.pix_y = PIX_W'(sum_y / recent_count);
      return point;
   endfunction

   function automatic void apply_register(logic [CSR_ADDR_W-1:0] addr,
         logic [CSR_DATA_W-1:0] data);
      case (addr)
         CSR_RAW_X_MIN:     cfg_x_min  = data[RAW_W-1:0];
         CSR_RAW_X_MAX:     cfg_x_max  = data[RAW_W-1:0];
         CSR_RAW_Y_MIN:     cfg_y_min  = data[RAW_W-1:0];
         CSR_RAW_Y_MAX:     cfg_y_max  = data[RAW_W-1:0];
         CSR_SCREEN_WIDTH:  cfg_width  = data[PIX_W-1:0];
         CSR_SCREEN_HEIGHT: cfg_height = data[PIX_W-1:0];
         CSR_ORIENT_FLAGS:  cfg_flags  = data[FLAG_W-1:0];
         default: ;
      endcase
   endfunction

   function automatic int pick_idle_limit();
      case ($urandom_range(0, 3))
         0: return 0;
         1: return 3;
         default: return 12;
      endcase
   endfunction

   function automatic logic [RAW_W-1:0] pick_bound();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return {RAW_W{1'b1}};
         default: return RAW_W'($urandom());
      endcase
   endfunction

   function automatic logic [CSR_DATA_W-1:0] pick_resolution();
      case ($urandom_range(0, 9))
         0: return CSR_DATA_W'(1);
         1: return CSR_DATA_W'(PIX_MAX);
         2: return CSR_DATA_W'($urandom());
         3: return '0;
         default: return CSR_DATA_W'({$urandom_range(0, 3), PIX_W'($urandom_range(16, 1023))});
      endcase
   endfunction

   function automatic logic [RAW_W-1:0] pick_raw();
      int pos;
      case ($urandom_range(0, 7))
         0: return $urandom_range(0, 1) ? {RAW_W{1'b1}} : {RAW_W{1'b0}};
         1, 2: begin
            case ($urandom_range(0, 3))
               0: pos = cfg_x_min;
               1: pos = cfg_x_max;
               2: pos = cfg_y_min;
               default: pos = cfg_y_max;
            endcase
            pos = pos + int'($urandom_range(0, 16)) - 8;
            if (pos < 0) pos = 0;
            if (pos > RAW_TOP) pos = RAW_TOP;
            return RAW_W'(pos);
         end
         default: return RAW_W'($urandom());
      endcase
   endfunction

   task automatic check_pixels(logic [PIX_W-1:0] pix_x, logic [PIX_W-1:0] pix_y);
      touch_point_type want;
      if (expected_points.size() == 0) begin
         $display("%0t: unexpected response x=%0d y=%0d", $time, pix_x, pix_y);
         fail_count++;
      end else begin
         want = expected_points.pop_front();
         if (want.pix_x !== pix_x) begin
            $display("%0t: pixel_x expected %0d actual %0d", $time, want.pix_x, pix_x);
            fail_count++;
         end
         if (want.pix_y !== pix_y) begin
            $display("%0t: pixel_y expected %0d actual %0d", $time, want.pix_y, pix_y);
            fail_count++;
         end
      end
   endtask

   initial begin
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (reset) begin
            rsp_if.ready <= 1'b0;
         end else begin
            if (rsp_if.valid && rsp_if.ready) begin
               check_pixels(rsp_if.pixel_x, rsp_if.pixel_y);
               rsp_stall_left = $urandom_range(0, rsp_stall_max);
            end
            if (rsp_hold_request) rsp_hold_left = HOLD_CYCLES;
            if (rsp_hold_left > 0) begin
               rsp_hold_left--;
               rsp_if.ready <= 1'b0;
            end else if (rsp_stall_left > 0) begin
               rsp_stall_left--;
               rsp_if.ready <= 1'b0;
            end else begin
               rsp_if.ready <= 1'b1;
            end
         end
      end
   end

   task automatic send_touch(logic [RAW_W-1:0] raw_x, logic [RAW_W-1:0] raw_y);
      int gap;
      gap = $urandom_range(0, req_gap_max);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.raw_x <= raw_x;
      req_if.raw_y <= raw_y;
      do @(posedge clock); while (!req_if.ready);
      expected_points.push_back(predict_touch(raw_x, raw_y));
   endtask

   task automatic write_register(logic [CSR_ADDR_W-1:0] addr, logic [CSR_DATA_W-1:0] data);
      csr_if.valid <= 1'b1;
      csr_if.addr  <= addr;
      csr_if.data  <= data;
      do @(posedge clock); while (!csr_if.ready);
      apply_register(addr, data);
      csr_if.valid <= 1'b0;
      @(posedge clock);
   endtask

   // drop the request line and wait until every response is back
   task automatic drain_requests();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (expected_points.size() > 0) @(posedge clock);
   endtask

   task automatic test_default_calibration();
      req_gap_max   = 0;
      rsp_stall_max = 0;
      send_touch(12'd0, 12'd0);
      send_touch(RST_RAW_X_MIN, RST_RAW_Y_MIN);
      send_touch(RST_RAW_X_MIN + 12'd1, RST_RAW_Y_MIN + 12'd1);
      send_touch(RST_RAW_X_MAX, RST_RAW_Y_MAX);
      send_touch(12'hFFF, 12'hFFF);
      send_touch(12'd2075, 12'd2077);
      drain_requests();
   endtask

   task automatic test_orientation_modes();
      logic [FLAG_W-1:0] modes [4];
      modes[0] = FLAG_W'(1 << FLAG_SWAP);
      modes[1] = FLAG_W'(1 << FLAG_INV_X);
      modes[2] = FLAG_W'(1 << FLAG_INV_Y);
      modes[3] = FLAG_W'((1 << FLAG_SWAP) | (1 << FLAG_INV_X) | (1 << FLAG_INV_Y));
      req_gap_max   = 3;
      rsp_stall_max = 3;
      foreach (modes[m]) begin
         write_register(CSR_ORIENT_FLAGS, CSR_DATA_W'(modes[m]));
         send_touch(12'd600, 12'd3000);
         send_touch(12'd3700, 12'd300);
         drain_requests();
      end
   endtask

   task automatic test_calibration_limits();
      req_gap_max   = 12;
      rsp_stall_max = 12;
      // negative span on x, zero span on y
      write_register(CSR_RAW_X_MIN, 12'hFFF);
      write_register(CSR_RAW_X_MAX, 12'd0);
      write_register(CSR_RAW_Y_MIN, 12'd2000);
      write_register(CSR_RAW_Y_MAX, 12'd2000);
      write_register(CSR_ORIENT_FLAGS, '0);
      send_touch(12'hFFF, 12'd2000);
      send_touch(12'd0, 12'hFFF);
      drain_requests();
      write_register(CSR_ORIENT_FLAGS,
                     CSR_DATA_W'((1 << FLAG_INV_X) | (1 << FLAG_INV_Y)));
      send_touch(12'd2048, 12'd1000);
      drain_requests();
      // saturation on x, inversion floor on y
      write_register(CSR_RAW_X_MIN, 12'd0);
      write_register(CSR_RAW_X_MAX, 12'd1);
      write_register(CSR_SCREEN_WIDTH, 12'hFFF);
      write_register(CSR_RAW_Y_MIN, 12'd0);
      write_register(CSR_RAW_Y_MAX, 12'd100);
      write_register(CSR_SCREEN_HEIGHT, 12'd500);
      write_register(CSR_ORIENT_FLAGS, CSR_DATA_W'(1 << FLAG_INV_Y));
      send_touch(12'hFFF, 12'hFFF);
      send_touch(12'd1, 12'd50);
      send_touch(12'd0, 12'd0);
      drain_requests();
      // zero and minimum resolution, write to an unused index
      write_register(CSR_SCREEN_WIDTH, 12'h400);
      write_register(CSR_SCREEN_HEIGHT, 12'd1);
      write_register(CSR_ORIENT_FLAGS, CSR_DATA_W'(1 << FLAG_INV_X));
      write_register(CSR_UNUSED, 12'hABC);
      send_touch(12'd2000, 12'd2000);
      send_touch(12'hFFF, 12'd0);
      drain_requests();
   endtask

   task automatic load_random_calibration();
      logic [RAW_W-1:0] lo_x;
      logic [RAW_W-1:0] hi_x;
      logic [RAW_W-1:0] lo_y;
      logic [RAW_W-1:0] hi_y;
      logic [RAW_W-1:0] swap;
      lo_x = pick_bound();
      hi_x = pick_bound();
      lo_y = pick_bound();
      hi_y = pick_bound();
      if ($urandom_range(0, 7) != 0 && lo_x > hi_x) begin
         swap = lo_x;
         lo_x = hi_x;
         hi_x = swap;
      end
      if ($urandom_range(0, 7) != 0 && lo_y > hi_y) begin
         swap = lo_y;
         lo_y = hi_y;
         hi_y = swap;
      end
      write_register(CSR_RAW_X_MIN, lo_x);
      write_register(CSR_RAW_X_MAX, hi_x);
      write_register(CSR_RAW_Y_MIN, lo_y);
      write_register(CSR_RAW_Y_MAX, hi_y);
      write_register(CSR_SCREEN_WIDTH, pick_resolution());
      write_register(CSR_SCREEN_HEIGHT, pick_resolution());
      write_register(CSR_ORIENT_FLAGS, CSR_DATA_W'($urandom()));
      if ($urandom_range(0, 3) == 0) write_register(CSR_UNUSED, CSR_DATA_W'($urandom()));
   endtask

   task automatic test_random_touches();
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         load_random_calibration();
         req_gap_max   = pick_idle_limit();
         rsp_stall_max = pick_idle_limit();
         for (int n = 0; n < PHASE_ITEMS; n++) send_touch(pick_raw(), pick_raw());
         drain_requests();
      end
   endtask

   // hold the response side while requests keep coming, so the core backs up
   task automatic test_output_backpressure();
      req_gap_max   = 0;
      rsp_stall_max = 0;
      rsp_hold_request <= 1'b1;
      @(posedge clock);
      rsp_hold_request <= 1'b0;
      for (int n = 0; n < 40; n++) send_touch(pick_raw(), pick_raw());
      drain_requests();
   endtask

   initial begin
      reset            <= 1'b1;
      rsp_hold_request <= 1'b0;
      req_if.valid     <= 1'b0;
      req_if.raw_x     <= '0;
      req_if.raw_y     <= '0;
      csr_if.valid     <= 1'b0;
      csr_if.addr      <= '0;
      csr_if.data      <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_default_calibration();
      test_orientation_modes();
      test_calibration_limits();
      test_output_backpressure();
      test_random_touches();

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
